// ===== src/sorted_timer_task_queue_unit_macros.svh =====
// assertion macros shared by the timer queue rtl
`ifndef SORTED_TIMER_TASK_QUEUE_UNIT_MACROS_SVH
`define SORTED_TIMER_TASK_QUEUE_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define STTQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// condition implies consequence in the next cycle
`define STTQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

// ===== src/sttq_pkg.sv =====
// types and codes shared by the timer queue cells and top level
package sttq_pkg;

  localparam int DUE_W = 49;
  localparam int PER_W = 48;

  localparam logic [2:0] MODE_SCHED     = 3'd0;
  localparam logic [2:0] MODE_SCHED_NOW = 3'd1;
  localparam logic [2:0] MODE_CANCEL    = 3'd2;
  localparam logic [2:0] MODE_EXISTS    = 3'd3;
  localparam logic [2:0] MODE_TICK      = 3'd4;
  localparam logic [2:0] MODE_CLEAR     = 3'd5;
  localparam logic [2:0] MODE_STOP      = 3'd6;
  localparam logic [2:0] MODE_START     = 3'd7;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_DLY = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_STOPPED = 2'd3;

  typedef enum logic [1:0] {
    OP_KEEP,
    OP_INSERT,
    OP_REMOVE,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    logic [DUE_W-1:0] due;
    logic [PER_W-1:0] per;
  } slot_t;

  typedef struct packed {
    cell_op_t         op;
    logic [DUE_W-1:0] key_due;
  } cell_ctrl_t;

endpackage

// ===== src/sttq_cell.sv =====
// one queue slot: holds an entry and shifts with its neighbors
module sttq_cell #(
  parameter int IDX = 0,
  parameter int TW  = 8,
  parameter int CW  = 6
) (
  input  logic                clk,
  input  sttq_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       cnt,
  input  logic [TW-1:0]       match_id,
  input  sttq_pkg::slot_t     ins_slot,
  input  logic [TW-1:0]       ins_task,
  input  sttq_pkg::slot_t     lft_slot,
  input  logic [TW-1:0]       lft_task,
  input  logic                ge_lft,
  input  sttq_pkg::slot_t     rgt_slot,
  input  logic [TW-1:0]       rgt_task,
  input  logic                rm_lft,
  output sttq_pkg::slot_t     slot,
  output logic [TW-1:0]       task_id,
  output logic                ge,
  output logic                rm
);
  import sttq_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  slot_t           slot_r;
  slot_t           slot_nxt;
  logic [TW-1:0]   task_r;
  logic [TW-1:0]   task_nxt;
  logic            used;

  assign used    = cnt > IDX_C;
  assign ge      = !used || (ctrl.key_due <= slot_r.due);
  assign rm      = rm_lft || (used && (task_r == match_id));
  assign slot    = slot_r;
  assign task_id = task_r;

  always_comb begin
    slot_nxt = slot_r;
    task_nxt = task_r;
    case (ctrl.op)
      OP_INSERT: begin
        if (ge) begin
          slot_nxt = ge_lft ? lft_slot : ins_slot;
          task_nxt = ge_lft ? lft_task : ins_task;
        end
      end
      OP_REMOVE: begin
        if (rm) begin
          slot_nxt = rgt_slot;
          task_nxt = rgt_task;
        end
      end
      OP_POP: begin
        slot_nxt = rgt_slot;
        task_nxt = rgt_task;
      end
      default: begin
        slot_nxt = slot_r;
        task_nxt = task_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    task_r <= task_nxt;
  end

endmodule

// ===== src/sorted_timer_task_queue_unit.sv =====
// sorted timer queue top level: command sequencer over a row of slot cells
//
//  channel | direction | ports
//  in      | request   | in_valid in_ready in_mode in_task_id in_delay in_repeat_req in_now
//  out     | result    | out_valid out_ready out_status out_fired out_fired_task
//          |           | out_found out_entry_count
//
//  a request goes from S_EXEC back to idle with its result registered on leaving S_EXEC;
//  a tick goes through S_EXEC and S_POP with its result registered on leaving S_POP
//  (reinsert of the held task, then head pop); the cell row sequencer runs one request
//  at a time
//  the last step waits while the result register is still full
//  rst_n (synchronous) empties the queue; slot contents are not cleared
module sorted_timer_task_queue_unit #(
  parameter int DEPTH        = 32,
  parameter int TASK_ID_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [7:0]         in_task_id,
  input  logic signed [47:0] in_delay,
  input  logic               in_repeat_req,
  input  logic [47:0]        in_now,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic               out_fired,
  output logic [7:0]         out_fired_task,
  output logic               out_found,
  output logic [5:0]         out_entry_count
);
  import sttq_pkg::*;

`include "sorted_timer_task_queue_unit_macros.svh"

  localparam int TW = TASK_ID_BITS;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
  localparam logic [CW-1:0] LIMIT_C = CW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            stop_r, stop_nxt;
  logic            held_r, held_nxt;
  logic [TW-1:0]   held_task_r, held_task_nxt;
  logic [47:0]     held_per_r, held_per_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            fired_r, fired_nxt;
  logic [7:0]      ftask_r, ftask_nxt;
  logic            found_r, found_nxt;
  logic [5:0]      ecnt_r, ecnt_nxt;

  logic [2:0]      md_r;
  logic [TW-1:0]   id_r;
  logic [47:0]     dly_r;
  logic            rep_r;
  logic [47:0]     now_r;

  cell_ctrl_t      ctrl;
  slot_t           ins_slot;
  logic [TW-1:0]   ins_task;
  logic            go;
  logic            load;
  logic            in_fire;
  logic [DUE_W-1:0] now_ext;
  logic [DUE_W-1:0] sched_due;
  logic [DUE_W-1:0] held_due;

  slot_t           c_slot [DEPTH];
  logic [TW-1:0]   c_task [DEPTH];
  logic            c_ge   [DEPTH];
  logic            c_rm   [DEPTH];

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign go        = !out_valid_r || out_ready;
  assign now_ext   = {1'b0, now_r};
  assign sched_due = now_ext + {1'b0, dly_r};
  assign held_due  = now_ext + {1'b0, held_per_r};

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      slot_t         l_slot, r_slot;
      logic [TW-1:0] l_task, r_task;
      logic          l_ge, l_rm;
      if (gi == 0) begin : g_first
        assign l_slot = '0;
        assign l_task = '0;
        assign l_ge   = 1'b0;
        assign l_rm   = 1'b0;
      end else begin : g_mid
        assign l_slot = c_slot[gi-1];
        assign l_task = c_task[gi-1];
        assign l_ge   = c_ge[gi-1];
        assign l_rm   = c_rm[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign r_slot = '0;
        assign r_task = '0;
      end else begin : g_inner
        assign r_slot = c_slot[gi+1];
        assign r_task = c_task[gi+1];
      end
      sttq_cell #(.IDX(gi), .TW(TW), .CW(CW)) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .cnt      (cnt_r),
        .match_id (id_r),
        .ins_slot (ins_slot),
        .ins_task (ins_task),
        .lft_slot (l_slot),
        .lft_task (l_task),
        .ge_lft   (l_ge),
        .rgt_slot (r_slot),
        .rgt_task (r_task),
        .rm_lft   (l_rm),
        .slot     (c_slot[gi]),
        .task_id  (c_task[gi]),
        .ge       (c_ge[gi]),
        .rm       (c_rm[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (in_fire) begin
      md_r  <= in_mode;
      id_r  <= TW'(in_task_id);
      dly_r <= in_delay;
      rep_r <= in_repeat_req;
      now_r <= in_now;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    stop_nxt      = stop_r;
    held_nxt      = held_r;
    held_task_nxt = held_task_r;
    held_per_nxt  = held_per_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    fired_nxt     = fired_r;
    ftask_nxt     = ftask_r;
    found_nxt     = found_r;
    load          = 1'b0;
    ctrl.op       = OP_KEEP;
    ctrl.key_due  = sched_due;
    ins_slot.due  = sched_due;
    ins_slot.per  = dly_r;
    ins_task      = id_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (md_r == MODE_TICK) begin
          // put back the held repeating task first
          ctrl.key_due = held_due;
          ins_slot.due = held_due;
          ins_slot.per = held_per_r;
          ins_task     = held_task_r;
          if (held_r) begin
            held_nxt = 1'b0;
            if (cnt_r < FULL_C) begin
              ctrl.op = OP_INSERT;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          state_nxt = S_POP;
        end else if (go) begin
          load       = 1'b1;
          status_nxt = STAT_OK;
          fired_nxt  = 1'b0;
          ftask_nxt  = 8'd0;
          found_nxt  = 1'b0;
          state_nxt  = S_IDLE;
          unique case (md_r)
            MODE_SCHED, MODE_SCHED_NOW: begin
              if (md_r == MODE_SCHED_NOW) begin
                ctrl.key_due = now_ext;
                ins_slot.due = now_ext;
              end
              if (!(md_r == MODE_SCHED_NOW || rep_r)) ins_slot.per = '0;
              if (dly_r[47]) begin
                status_nxt = STAT_BAD_DLY;
              end else if (cnt_r >= FULL_C) begin
                status_nxt = STAT_FULL;
              end else if (stop_r) begin
                status_nxt = STAT_STOPPED;
              end else if (held_r && cnt_r >= LIMIT_C) begin
                status_nxt = STAT_FULL;
              end else begin
                ctrl.op = OP_INSERT;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            MODE_CANCEL: begin
              if (c_rm[DEPTH-1]) begin
                ctrl.op = OP_REMOVE;
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            MODE_EXISTS: found_nxt = c_rm[DEPTH-1];
            MODE_TICK:   cnt_nxt = cnt_r;
            MODE_CLEAR:  cnt_nxt = '0;
            MODE_STOP:   stop_nxt = 1'b1;
            MODE_START:  stop_nxt = 1'b0;
          endcase
        end
      end
      S_POP: begin
        if (go) begin
          load       = 1'b1;
          status_nxt = STAT_OK;
          fired_nxt  = 1'b0;
          ftask_nxt  = 8'd0;
          found_nxt  = 1'b0;
          state_nxt  = S_IDLE;
          if (!stop_r && cnt_r != '0 && c_slot[0].due <= now_ext) begin
            ctrl.op   = OP_POP;
            cnt_nxt   = cnt_r - 1'b1;
            fired_nxt = 1'b1;
            ftask_nxt = 8'(c_task[0]);
            if (c_slot[0].per != '0) begin
              held_nxt      = 1'b1;
              held_task_nxt = c_task[0];
              held_per_nxt  = c_slot[0].per;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (load) out_valid_nxt = 1'b1;
    ecnt_nxt = load ? 6'(cnt_nxt) : ecnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      stop_r      <= 1'b0;
      held_r      <= 1'b0;
      held_task_r <= '0;
      held_per_r  <= '0;
      out_valid_r <= 1'b0;
      status_r    <= STAT_OK;
      fired_r     <= 1'b0;
      ftask_r     <= 8'd0;
      found_r     <= 1'b0;
      ecnt_r      <= 6'd0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      stop_r      <= stop_nxt;
      held_r      <= held_nxt;
      held_task_r <= held_task_nxt;
      held_per_r  <= held_per_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      fired_r     <= fired_nxt;
      ftask_r     <= ftask_nxt;
      found_r     <= found_nxt;
      ecnt_r      <= ecnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_fired       = fired_r;
  assign out_fired_task  = ftask_r;
  assign out_found       = found_r;
  assign out_entry_count = ecnt_r;

  `STTQ_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= FULL_C)
  `STTQ_ASSERT_SAME(a_fired_clean, out_valid_r && fired_r, status_r == STAT_OK && !found_r)
  `STTQ_ASSERT_NEXT(a_accept_exec, in_fire, state_r == S_EXEC)
  `STTQ_ASSERT_SAME(a_held_from_pop, $rose(held_r), $past(state_r) == S_POP)
  `STTQ_ASSERT_NEXT(a_pop_after_tick, state_r == S_EXEC && md_r == MODE_TICK, state_r == S_POP)

endmodule

// ===== verif/tb_top.sv =====
// testbench for the sorted timer task queue: random and directed requests, predicted results
`timescale 1ns / 1ps

module tb_top;
  import sttq_pkg::*;

  localparam int DEPTH        = 32;
  localparam int TASK_ID_BITS = 8;
  localparam int STALL_LIMIT  = 3000;
  localparam int TOTAL_REQS   = 1225;

  typedef struct {
    logic [2:0]  mode;
    logic [7:0]  task_id;
    logic [47:0] delay;
    logic        repeat_req;
    logic [47:0] now;
  } timer_req_t;

  typedef struct {
    logic [1:0] status;
    logic       fired;
    logic [7:0] fired_task;
    logic       found;
    logic [5:0] entry_count;
  } timer_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_mode = MODE_SCHED;
  logic [7:0]         in_task_id = '0;
  logic signed [47:0] in_delay = '0;
  logic               in_repeat_req = 1'b0;
  logic [47:0]        in_now = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic               out_fired;
  logic [7:0]         out_fired_task;
  logic               out_found;
  logic [5:0]         out_entry_count;

  sorted_timer_task_queue_unit #(
    .DEPTH(DEPTH),
    .TASK_ID_BITS(TASK_ID_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_task_id(in_task_id),
    .in_delay(in_delay),
    .in_repeat_req(in_repeat_req),
    .in_now(in_now),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_fired(out_fired),
    .out_fired_task(out_fired_task),
    .out_found(out_found),
    .out_entry_count(out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the timer queue
  logic [48:0] shadow_due [DEPTH];
  logic [47:0] shadow_per [DEPTH];
  logic [7:0]  shadow_id  [DEPTH];
  int          shadow_count;
  bit          shadow_stopped;
  bit          shadow_held;
  logic [7:0]  shadow_held_id;
  logic [47:0] shadow_held_per;

  timer_req_t  sched_reqs[$];
  timer_res_t  due_results[$];
  timer_req_t  cur_req;
  timer_res_t  exp_res;

  int errors = 0;
  int reqs_sent = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int n_sched = 0;
  int n_rejected = 0;
  int n_fired = 0;
  int n_found = 0;
  int peak_count = 0;

  function automatic bit shadow_insert(logic [48:0] due, logic [47:0] per, logic [7:0] id,
                                       int limit);
    int pos;
    if (shadow_count >= limit || shadow_count >= DEPTH) return 1'b0;
    pos = 0;
    while (pos < shadow_count && due > shadow_due[pos]) pos++;
    for (int i = shadow_count; i > pos; i--) begin
      shadow_due[i] = shadow_due[i-1];
      shadow_per[i] = shadow_per[i-1];
      shadow_id[i]  = shadow_id[i-1];
    end
    shadow_due[pos] = due;
    shadow_per[pos] = per;
    shadow_id[pos]  = id;
    shadow_count++;
    return 1'b1;
  endfunction

  function automatic void shadow_remove(int pos);
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_due[i] = shadow_due[i+1];
      shadow_per[i] = shadow_per[i+1];
      shadow_id[i]  = shadow_id[i+1];
    end
    if (shadow_count > 0) shadow_count--;
  endfunction

  function automatic void timer_queue_step(timer_req_t r);
    timer_res_t  res;
    int          limit;
    logic [48:0] due;
    logic [47:0] per;
    logic [47:0] pop_per;
    res = '{status: STAT_OK, fired: 1'b0, fired_task: '0, found: 1'b0, entry_count: '0};
    case (r.mode)
      MODE_SCHED, MODE_SCHED_NOW: begin
        n_sched++;
        limit = shadow_held ? DEPTH - 1 : DEPTH;
        if (r.delay[47]) begin
          res.status = STAT_BAD_DLY;
        end else if (shadow_count >= DEPTH) begin
          res.status = STAT_FULL;
        end else if (shadow_stopped) begin
          res.status = STAT_STOPPED;
        end else begin
          due = (r.mode == MODE_SCHED_NOW) ? {1'b0, r.now} : {1'b0, r.now} + {1'b0, r.delay};
          per = (r.mode == MODE_SCHED_NOW || r.repeat_req) ? r.delay : '0;
          if (!shadow_insert(due, per, r.task_id, limit)) res.status = STAT_FULL;
        end
        if (res.status != STAT_OK) n_rejected++;
      end
      MODE_CANCEL: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_id[i] == r.task_id) begin
            shadow_remove(i);
            break;
          end
        end
      end
      MODE_EXISTS: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_id[i] == r.task_id) begin
            res.found = 1'b1;
            break;
          end
        end
        if (res.found) n_found++;
      end
      MODE_TICK: begin
        if (shadow_held) begin
          shadow_held = 1'b0;
          void'(shadow_insert({1'b0, r.now} + {1'b0, shadow_held_per}, shadow_held_per,
                              shadow_held_id, DEPTH));
        end
        if (!shadow_stopped && shadow_count > 0 && shadow_due[0] <= {1'b0, r.now}) begin
          pop_per = shadow_per[0];
          res.fired = 1'b1;
          res.fired_task = shadow_id[0];
          shadow_remove(0);
          n_fired++;
          if (pop_per != '0) begin
            shadow_held = 1'b1;
            shadow_held_id = res.fired_task;
            shadow_held_per = pop_per;
          end
        end
      end
      MODE_CLEAR: shadow_count = 0;
      MODE_STOP:  shadow_stopped = 1'b1;
      default:    shadow_stopped = 1'b0;
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
    res.entry_count = shadow_count[5:0];
    due_results.push_back(res);
  endfunction

  function automatic logic [47:0] rand48();
    logic [47:0] v;
    v[47:32] = 16'($urandom_range(0, 65535));
    v[31:0]  = $urandom();
    return v;
  endfunction

  function automatic logic [47:0] pick_delay();
    int          roll;
    logic [47:0] v;
    roll = $urandom_range(0, 99);
    if (roll < 55) v = 48'($urandom_range(1, 40));
    else if (roll < 72) v = '0;
    else if (roll < 84) v = 48'($urandom_range(0, 5000));
    else if (roll < 92) begin
      v = rand48();
      v[47] = 1'b0;
    end else begin
      v = rand48();
      v[47] = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [7:0] pick_id();
    if ($urandom_range(0, 99) < 80) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_req(logic [2:0] m, logic [7:0] id, logic [47:0] d, logic rp,
                                   logic [47:0] t);
    timer_req_t r;
    r.mode = m;
    r.task_id = id;
    r.delay = d;
    r.repeat_req = rp;
    r.now = t;
    sched_reqs.push_back(r);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        timer_queue_step(cur_req);
        reqs_sent++;
      end
      if (!in_valid || in_ready) begin
        if (sched_reqs.size() != 0 &&
            ((reqs_sent >= 500 && reqs_sent < 800) || $urandom_range(0, 99) >= 24)) begin
          cur_req = sched_reqs.pop_front();
          in_mode       <= cur_req.mode;
          in_task_id    <= cur_req.task_id;
          in_delay      <= cur_req.delay;
          in_repeat_req <= cur_req.repeat_req;
          in_now        <= cur_req.now;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (due_results.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          exp_res = due_results.pop_front();
          if (out_status !== exp_res.status) begin
            $error("status expected %0d actual %0d", exp_res.status, out_status);
            errors++;
          end
          if (out_fired !== exp_res.fired) begin
            $error("fired expected %0d actual %0d", exp_res.fired, out_fired);
            errors++;
          end
          if (out_fired_task !== exp_res.fired_task) begin
            $error("fired_task expected %0d actual %0d", exp_res.fired_task, out_fired_task);
            errors++;
          end
          if (out_found !== exp_res.found) begin
            $error("found expected %0d actual %0d", exp_res.found, out_found);
            errors++;
          end
          if (out_entry_count !== exp_res.entry_count) begin
            $error("entry_count expected %0d actual %0d", exp_res.entry_count, out_entry_count);
            errors++;
          end
        end
      end
      // long hold-off so the queue backs up into the request side
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 550) begin
        hold_done <= 1'b1;
        hold_left <= 150;
        out_ready <= 1'b0;
      end else if (results_seen >= 600 && results_seen < 850) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 24);
      end
    end
  end

  initial begin
    logic [47:0] tbase;
    int          kind;
    int          n;
    int          roll;

    shadow_count = 0;
    shadow_stopped = 1'b0;
    shadow_held = 1'b0;
    shadow_held_id = '0;
    shadow_held_per = '0;

    // directed part
    push_req(MODE_EXISTS, 8'd0, 48'd0, 1'b0, 48'd0);
    push_req(MODE_TICK, 8'd0, 48'd0, 1'b0, 48'd0);
    push_req(MODE_SCHED, 8'd0, 48'd0, 1'b0, 48'd0);
    push_req(MODE_SCHED, 8'd255, 48'h7FFF_FFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF);
    push_req(MODE_SCHED, 8'd5, 48'h8000_0000_0000, 1'b0, 48'd3);
    push_req(MODE_SCHED, 8'd6, 48'hFFFF_FFFF_FFFF, 1'b1, 48'd3);
    push_req(MODE_SCHED, 8'd7, 48'd0, 1'b1, 48'd10);
    push_req(MODE_SCHED_NOW, 8'd8, 48'd20, 1'b0, 48'd10);
    push_req(MODE_EXISTS, 8'd255, 48'd0, 1'b0, 48'd10);
    push_req(MODE_CANCEL, 8'd99, 48'd0, 1'b0, 48'd10);
    push_req(MODE_CANCEL, 8'd255, 48'd0, 1'b0, 48'd10);
    push_req(MODE_TICK, 8'd0, 48'd0, 1'b0, 48'd10);
    push_req(MODE_TICK, 8'd0, 48'd0, 1'b0, 48'd10);
    push_req(MODE_STOP, 8'd0, 48'd0, 1'b0, 48'd12);
    push_req(MODE_SCHED, 8'd9, 48'd1, 1'b0, 48'd12);
    push_req(MODE_TICK, 8'd0, 48'd0, 1'b0, 48'd10);
    push_req(MODE_START, 8'd0, 48'd0, 1'b0, 48'd40);
    push_req(MODE_TICK, 8'd0, 48'd0, 1'b0, 48'd40);
    push_req(MODE_TICK, 8'd0, 48'd0, 1'b0, 48'd40);
    push_req(MODE_SCHED, 8'd10, 48'd3, 1'b0, 48'd40);
    push_req(MODE_CLEAR, 8'd0, 48'd0, 1'b0, 48'd41);
    push_req(MODE_TICK, 8'd0, 48'd0, 1'b0, 48'd100);
    push_req(MODE_SCHED_NOW, 8'd11, 48'hFFFF_FFFF_FF00, 1'b0, 48'd100);
    push_req(MODE_EXISTS, 8'd8, 48'd0, 1'b0, 48'd100);

    tbase = 48'd200;
    while (sched_reqs.size() < TOTAL_REQS) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        // burst of schedules, often enough to fill the queue
        n = $urandom_range(4, 36);
        repeat (n) begin
          tbase = tbase + 48'($urandom_range(0, 3));
          push_req(($urandom_range(0, 99) < 80) ? MODE_SCHED : MODE_SCHED_NOW, pick_id(),
                   pick_delay(), 1'($urandom_range(0, 1)), tbase);
        end
      end else if (kind < 55) begin
        n = $urandom_range(3, 20);
        repeat (n) begin
          tbase = tbase + 48'($urandom_range(0, 30));
          roll = $urandom_range(0, 99);
          if (roll < 75) push_req(MODE_TICK, pick_id(), pick_delay(), 1'b0, tbase);
          else if (roll < 85) push_req(MODE_EXISTS, pick_id(), 48'd0, 1'b0, tbase);
          else if (roll < 93) push_req(MODE_CANCEL, pick_id(), 48'd0, 1'b0, tbase);
          else push_req(MODE_SCHED, pick_id(), pick_delay(), 1'b1, tbase);
        end
      end else if (kind < 75) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          tbase = tbase + 48'($urandom_range(0, 10));
          roll = $urandom_range(0, 11);
          case (roll)
            0, 1, 2: push_req(MODE_SCHED, pick_id(), pick_delay(), 1'($urandom_range(0, 1)),
                              tbase);
            3:       push_req(MODE_SCHED_NOW, pick_id(), pick_delay(), 1'b0, tbase);
            4, 5:    push_req(MODE_CANCEL, pick_id(), pick_delay(), 1'b0, tbase);
            6, 7:    push_req(MODE_EXISTS, pick_id(), pick_delay(), 1'b0, tbase);
            8, 9, 10: push_req(MODE_TICK, pick_id(), pick_delay(), 1'b0, tbase);
            default: push_req(MODE_START, pick_id(), pick_delay(), 1'b0, tbase);
          endcase
        end
      end else if (kind < 82) begin
        push_req(MODE_STOP, pick_id(), pick_delay(), 1'b0, tbase);
        n = $urandom_range(1, 6);
        repeat (n) begin
          tbase = tbase + 48'($urandom_range(0, 40));
          if ($urandom_range(0, 1)) push_req(MODE_TICK, 8'd0, 48'd0, 1'b0, tbase);
          else push_req(MODE_SCHED, pick_id(), pick_delay(), 1'($urandom_range(0, 1)), tbase);
        end
        push_req(MODE_START, pick_id(), pick_delay(), 1'b0, tbase);
      end else if (kind < 86) begin
        push_req(MODE_CLEAR, pick_id(), pick_delay(), 1'($urandom_range(0, 1)), tbase);
      end else if (kind < 90) begin
        // jump the time base, sometimes close to wraparound
        if ($urandom_range(0, 1)) tbase = rand48();
        else tbase = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 200));
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          push_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), rand48(),
                   1'($urandom_range(0, 1)), rand48());
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while ((sched_reqs.size() != 0 || in_valid || due_results.size() != 0) &&
           stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
    end

    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", stall_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      $display("ran %0d requests: %0d schedules (%0d rejected), %0d fired ticks", reqs_sent,
               n_sched, n_rejected, n_fired);
      $display("exists hits %0d, peak queue depth %0d, mismatches %0d", n_found, peak_count,
               errors);
      if (errors == 0 && due_results.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
      $finish;
    end
  end

endmodule

// ===== sorted_timer_task_queue_unit.f =====
+incdir+src
src/sttq_pkg.sv
src/sttq_cell.sv
src/sorted_timer_task_queue_unit.sv
verif/tb_top.sv
